FILE: sv/fixed_point_alu_core_macros.svh
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_CORE_MACROS_SVH
`define FIXED_POINT_ALU_CORE_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/fpa_pkg.sv
// shared types, codes and helpers for the fixed-point alu
package fpa_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   localparam logic [3:0] CMD_ADD = 4'd0;
   localparam logic [3:0] CMD_SUB = 4'd1;
   localparam logic [3:0] CMD_MUL = 4'd2;
   localparam logic [3:0] CMD_DIV = 4'd3;
   localparam logic [3:0] CMD_GT  = 4'd4;
   localparam logic [3:0] CMD_LT  = 4'd5;
   localparam logic [3:0] CMD_GE  = 4'd6;
   localparam logic [3:0] CMD_LE  = 4'd7;
   localparam logic [3:0] CMD_EQ  = 4'd8;
   localparam logic [3:0] CMD_NE  = 4'd9;
   localparam logic [3:0] CMD_MIN = 4'd10;
   localparam logic [3:0] CMD_MAX = 4'd11;
   localparam logic [3:0] CMD_INC = 4'd12;
   localparam logic [3:0] CMD_DEC = 4'd13;
   localparam logic [3:0] CMD_ITF = 4'd14;
   localparam logic [3:0] CMD_FTI = 4'd15;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] res;
      logic        ovf;
   } fpa_sat_type;

   typedef struct packed {
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  st;
      logic        is_div;
      logic        neg;
      logic        a_neg;
      logic        div0;
   } fpa_side_type;

   // sign plus magnitude into 32 bits with saturation
   function automatic fpa_sat_type pack_sat(input logic neg, input logic [63:0] m);
      fpa_sat_type r;
      r.ovf = 1'b0;
      if (!neg) begin
         if (m > 64'(POS_MAX)) begin
            r.res = POS_MAX;
            r.ovf = 1'b1;
         end else begin
            r.res = m[31:0];
         end
      end else begin
         if (m > 64'(NEG_MAX)) begin
            r.res = NEG_MAX;
            r.ovf = 1'b1;
         end else begin
            r.res = ~m[31:0] + 32'd1;
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/fpa_front.sv
// operand decode, multiply and non-divide results, two stages
module fpa_front #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   parameter int NW = 32 + FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [3:0]          cmd,
   input  logic signed [31:0]  operand_a,
   input  logic signed [31:0]  operand_b,
   output logic                out_valid,
   output fpa_pkg::fpa_side_type out_side,
   output logic [31:0]         out_rem,
   output logic [31:0]         out_den,
   output logic [NW-1:0]       out_nq
);

   logic               v1_ff;
   logic [3:0]         cmd_ff;
   logic signed [31:0] a_ff, b_ff;
   logic [31:0]        ma_ff, mb_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        ma_in, mb_in;

   logic               v2_ff;
   fpa_pkg::fpa_side_type side_ff, side_in;
   logic [31:0]        den_ff;
   logic [NW-1:0]      nq_ff;

   logic [63:0]        mul_q, itf_m, fti_m;
   fpa_pkg::fpa_sat_type mul_s, itf_s, fti_s;
   logic               le;

   assign ma_in = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
   assign mb_in = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff  <= cmd;
         a_ff    <= operand_a;
         b_ff    <= operand_b;
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         prod_ff <= 64'(ma_in) * 64'(mb_in);
         side_ff <= side_in;
         den_ff  <= mb_ff;
         nq_ff   <= NW'({ma_ff, {FRAC_BITS{1'b0}}});
      end
   end

   assign mul_q = (prod_ff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign itf_m = {32'd0, ma_ff} << FRAC_BITS;
   assign fti_m = {32'd0, ma_ff} >> FRAC_BITS;
   assign mul_s = fpa_pkg::pack_sat(a_ff[31] ^ b_ff[31], mul_q);
   assign itf_s = fpa_pkg::pack_sat(a_ff[31], itf_m);
   assign fti_s = fpa_pkg::pack_sat(a_ff[31], fti_m);
   assign le    = (a_ff <= b_ff);

   always_comb begin
      side_in        = '0;
      side_in.neg    = a_ff[31] ^ b_ff[31];
      side_in.a_neg  = a_ff[31];
      side_in.div0   = (b_ff == 32'sd0);
      side_in.st     = fpa_pkg::ST_OK;
      unique case (cmd_ff)
         fpa_pkg::CMD_ADD: side_in.res = a_ff + b_ff;
         fpa_pkg::CMD_SUB: side_in.res = a_ff - b_ff;
         fpa_pkg::CMD_MUL: begin
            side_in.res = mul_s.res;
            side_in.st  = mul_s.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end
         fpa_pkg::CMD_DIV: side_in.is_div = 1'b1;
         fpa_pkg::CMD_GT:  side_in.cmp = (a_ff > b_ff);
         fpa_pkg::CMD_LT:  side_in.cmp = (a_ff < b_ff);
         fpa_pkg::CMD_GE:  side_in.cmp = (a_ff >= b_ff);
         fpa_pkg::CMD_LE:  side_in.cmp = le;
         fpa_pkg::CMD_EQ:  side_in.cmp = (a_ff == b_ff);
         fpa_pkg::CMD_NE:  side_in.cmp = (a_ff != b_ff);
         fpa_pkg::CMD_MIN: side_in.res = le ? a_ff : b_ff;
         fpa_pkg::CMD_MAX: side_in.res = le ? b_ff : a_ff;
         fpa_pkg::CMD_INC: side_in.res = a_ff + 32'sd1;
         fpa_pkg::CMD_DEC: side_in.res = a_ff - 32'sd1;
         fpa_pkg::CMD_ITF: begin
            side_in.res = itf_s.res;
            side_in.st  = itf_s.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end
         fpa_pkg::CMD_FTI: side_in.res = fti_s.res;
         default: side_in.res = '0;
      endcase
   end

   assign out_valid = v2_ff;
   assign out_side  = side_ff;
   assign out_rem   = '0;
   assign out_den   = den_ff;
   assign out_nq    = nq_ff;

endmodule

FILE: sv/fpa_div_cell.sv
// one restoring divide cell, one quotient bit per cell
module fpa_div_cell #(
   parameter int NW = 32 + fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  fpa_pkg::fpa_side_type in_side,
   input  logic [31:0]           in_rem,
   input  logic [31:0]           in_den,
   input  logic [NW-1:0]         in_nq,
   output logic                  out_valid,
   output fpa_pkg::fpa_side_type out_side,
   output logic [31:0]           out_rem,
   output logic [31:0]           out_den,
   output logic [NW-1:0]         out_nq
);

   logic                  valid_ff;
   fpa_pkg::fpa_side_type side_ff;
   logic [31:0]           rem_ff, den_ff, rem_in;
   logic [NW-1:0]         nq_ff;
   logic [32:0]           shifted, diff;
   logic                  ge;

   assign shifted = {in_rem, in_nq[NW-1]};
   assign ge      = (shifted >= {1'b0, in_den});
   assign diff    = shifted - {1'b0, in_den};
   assign rem_in  = ge ? diff[31:0] : shifted[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         nq_ff   <= {in_nq[NW-2:0], ge};
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_nq    = nq_ff;

endmodule

FILE: sv/fpa_back.sv
// divide rounding, saturation and the output register
module fpa_back #(
   parameter int NW = 32 + fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  fpa_pkg::fpa_side_type in_side,
   input  logic [31:0]           in_rem,
   input  logic [31:0]           in_den,
   input  logic [NW-1:0]         in_nq,
   output logic                  out_valid,
   output logic [31:0]           out_result,
   output logic                  out_cmp,
   output logic [1:0]            out_status
);

   logic                 valid_ff;
   logic [31:0]          result_ff, result_in;
   logic                 cmp_ff;
   logic [1:0]           status_ff, status_in;
   logic                 rnd;
   logic [NW:0]          qr;
   fpa_pkg::fpa_sat_type div_s;

   assign rnd   = ({in_rem, 1'b0} >= {1'b0, in_den});
   assign qr    = {1'b0, in_nq} + (NW+1)'(rnd);
   assign div_s = fpa_pkg::pack_sat(in_side.neg, 64'(qr));

   always_comb begin
      result_in = in_side.res;
      status_in = in_side.st;
      if (in_side.is_div) begin
         if (in_side.div0) begin
            result_in = in_side.a_neg ? fpa_pkg::NEG_MAX : fpa_pkg::POS_MAX;
            status_in = fpa_pkg::ST_DIV0;
         end else begin
            result_in = div_s.res;
            status_in = div_s.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         cmp_ff    <= in_side.cmp;
         status_ff <= status_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_cmp    = cmp_ff;
   assign out_status = status_ff;

endmodule

FILE: sv/fixed_point_alu_core.sv
// top level of the pipelined signed fixed-point alu
// usage:
//  req channel: req_valid/req_ready with req_cmd, req_operand_a, req_operand_b
//  rsp channel: rsp_valid/rsp_ready with rsp_result, rsp_compare_true, rsp_status
//  every item gives exactly one result item, in order
//  from accept to rsp_valid each item passes through, in order:
//   two front stages (operand decode and multiply, then result select),
//   one divide cell per quotient bit (32 + FRAC_BITS cells), one output stage
//  all commands take the same path, so throughput is one item per cycle while the output is not stalled
//  the whole pipeline advances together; it moves whenever the output
//  register is empty or its item is being taken
//  when the receiver stalls, req_ready drops and every stage holds
//  synchronous active-high reset clears all valid bits; nothing else needs it
//  there is no configuration and no state between items
`include "fixed_point_alu_core_macros.svh"
module fixed_point_alu_core #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_cmd,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result,
   output logic               rsp_compare_true,
   output logic [1:0]         rsp_status
);

   localparam int NW = 32 + FRAC_BITS;

   logic                  adv;
   logic                  v_chain [0:NW];
   fpa_pkg::fpa_side_type s_chain [0:NW];
   logic [31:0]           r_chain [0:NW];
   logic [31:0]           d_chain [0:NW];
   logic [NW-1:0]         q_chain [0:NW];
   logic [31:0]           res_w;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fpa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .cmd       (req_cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_valid (v_chain[0]),
      .out_side  (s_chain[0]),
      .out_rem   (r_chain[0]),
      .out_den   (d_chain[0]),
      .out_nq    (q_chain[0])
   );

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_div_cell #(.NW(NW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (v_chain[i]),
         .in_side   (s_chain[i]),
         .in_rem    (r_chain[i]),
         .in_den    (d_chain[i]),
         .in_nq     (q_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_side  (s_chain[i+1]),
         .out_rem   (r_chain[i+1]),
         .out_den   (d_chain[i+1]),
         .out_nq    (q_chain[i+1])
      );
   end

   fpa_back #(.NW(NW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (v_chain[NW]),
      .in_side    (s_chain[NW]),
      .in_rem     (r_chain[NW]),
      .in_den     (d_chain[NW]),
      .in_nq      (q_chain[NW]),
      .out_valid  (rsp_valid),
      .out_result (res_w),
      .out_cmp    (rsp_compare_true),
      .out_status (rsp_status)
   );

   assign rsp_result = res_w;

   `FPA_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `FPA_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result))
   `FPA_ASSERT_NOW(a_cmp_clean, clock, reset, rsp_valid && rsp_compare_true, rsp_result == 32'sd0 && rsp_status == fpa_pkg::ST_OK)
   `FPA_ASSERT_NOW(a_div0_sat, clock, reset, rsp_valid && rsp_status == fpa_pkg::ST_DIV0, rsp_result == fpa_pkg::POS_MAX || rsp_result == fpa_pkg::NEG_MAX)

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the pipelined signed fixed-point alu
module testbench;

   localparam int FRAC = fpa_pkg::FRAC_BITS_DEFAULT;
   localparam int N_RANDOM = 1550;
   localparam int LATENCY = FRAC + 35;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [31:0] PMAX = fpa_pkg::POS_MAX;
   localparam logic [31:0] NMAX = fpa_pkg::NEG_MAX;

   typedef struct {
      logic [3:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      logic        known;
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  st;
   } row_type;

   typedef struct {
      logic [31:0] res;
      logic        cmp;
      logic [1:0]  st;
   } alu_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_cmd = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_result;
   logic rsp_compare_true;
   logic [1:0] rsp_status;

   alu_out_type pending_q[$];
   int errors = 0;
   int stall_left = 0;
   longint cycles = 0;
   bit driving_done = 1'b0;

   fixed_point_alu_core dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? 64'(-$signed({1'b1, v})) & 64'h1_FFFF_FFFF : 64'(v);
   endfunction

   function automatic alu_out_type saturate(logic neg, logic [63:0] m);
      alu_out_type o;
      o.cmp = 1'b0;
      o.st = fpa_pkg::ST_OK;
      if (!neg) begin
         if (m > 64'(PMAX)) begin
            o.res = PMAX;
            o.st = fpa_pkg::ST_OVF;
         end else o.res = m[31:0];
      end else begin
         if (m > 64'(NMAX)) begin
            o.res = NMAX;
            o.st = fpa_pkg::ST_OVF;
         end else o.res = 32'(64'h1_0000_0000 - m);
      end
      return o;
   endfunction

   function automatic alu_out_type fixed_alu(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      alu_out_type o;
      logic signed [31:0] sa, sb;
      logic [127:0] num, q, r, den, p;
      logic neg;
      sa = a;
      sb = b;
      o = '{res: '0, cmp: 1'b0, st: fpa_pkg::ST_OK};
      neg = a[31] ^ b[31];
      case (cmd)
         fpa_pkg::CMD_ADD: o.res = a + b;
         fpa_pkg::CMD_SUB: o.res = a - b;
         fpa_pkg::CMD_MUL: begin
            p = 128'(magnitude(a)) * 128'(magnitude(b));
            q = (p + (128'd1 << (FRAC - 1))) >> FRAC;
            o = saturate(neg, (q > 128'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : q[63:0]);
         end
         fpa_pkg::CMD_DIV: begin
            if (b == 0) begin
               o.st = fpa_pkg::ST_DIV0;
               o.res = a[31] ? NMAX : PMAX;
            end else begin
               num = 128'(magnitude(a)) << FRAC;
               den = 128'(magnitude(b));
               q = num / den;
               r = num % den;
               if (2 * r >= den) q = q + 1;
               o = saturate(neg, q[63:0]);
            end
         end
         fpa_pkg::CMD_GT: o.cmp = sa > sb;
         fpa_pkg::CMD_LT: o.cmp = sa < sb;
         fpa_pkg::CMD_GE: o.cmp = sa >= sb;
         fpa_pkg::CMD_LE: o.cmp = sa <= sb;
         fpa_pkg::CMD_EQ: o.cmp = sa == sb;
         fpa_pkg::CMD_NE: o.cmp = sa != sb;
         fpa_pkg::CMD_MIN: o.res = (sa <= sb) ? a : b;
         fpa_pkg::CMD_MAX: o.res = (sa <= sb) ? b : a;
         fpa_pkg::CMD_INC: o.res = a + 32'd1;
         fpa_pkg::CMD_DEC: o.res = a - 32'd1;
         fpa_pkg::CMD_ITF: o = saturate(a[31], magnitude(a) << FRAC);
         default: begin
            o = saturate(a[31], magnitude(a) >> FRAC);
            o.st = fpa_pkg::ST_OK;
         end
      endcase
      return o;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      pending_q.push_back(fixed_alu(cmd, a, b));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 2000) - 1000;
         1: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
         2: return $urandom_range(0, 1) ? PMAX - $urandom_range(0, 3)
                                        : NMAX + $urandom_range(0, 3);
         3: return ($urandom_range(0, 300) - 150) << FRAC;
         4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // receiver with random stalls
   always @(posedge clock) begin
      alu_out_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_q.size() == 0) begin
               report("unexpected item", rsp_result, 32'd0);
            end else begin
               want = pending_q.pop_front();
               if (rsp_result !== want.res) report("result", rsp_result, want.res);
               if (rsp_compare_true !== want.cmp)
                  report("compare_true", 32'(rsp_compare_true), 32'(want.cmp));
               if (rsp_status !== want.st) report("status", 32'(rsp_status), 32'(want.st));
            end
         end
         if (driving_done) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= gap_len();
         end
      end
   end

   row_type directed[] = '{
      '{fpa_pkg::CMD_ADD, PMAX, 32'd1, 1'b1, NMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_SUB, NMAX, 32'd1, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_MUL, PMAX, PMAX, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OVF},
      '{fpa_pkg::CMD_MUL, NMAX, NMAX, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OVF},
      '{fpa_pkg::CMD_MUL, NMAX, 32'h100, 1'b1, NMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_MUL, 32'h180, 32'h1, 1'b0, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_MUL, 32'hFFFF_FE80, 32'h1, 1'b0, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_DIV, 32'd5, 32'd0, 1'b1, PMAX, 1'b0, fpa_pkg::ST_DIV0},
      '{fpa_pkg::CMD_DIV, 32'd0, 32'd0, 1'b1, PMAX, 1'b0, fpa_pkg::ST_DIV0},
      '{fpa_pkg::CMD_DIV, NMAX, 32'd0, 1'b1, NMAX, 1'b0, fpa_pkg::ST_DIV0},
      '{fpa_pkg::CMD_DIV, NMAX, 32'hFFFF_FFFF, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OVF},
      '{fpa_pkg::CMD_DIV, 32'd1, 32'd512, 1'b0, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'd512, 1'b0, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_GT, NMAX, PMAX, 1'b1, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_LT, NMAX, PMAX, 1'b1, '0, 1'b1, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_GE, 32'd7, 32'd7, 1'b1, '0, 1'b1, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_LE, 32'd8, 32'd7, 1'b1, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_EQ, NMAX, NMAX, 1'b1, '0, 1'b1, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_NE, NMAX, NMAX, 1'b1, '0, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_MIN, NMAX, PMAX, 1'b1, NMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_MAX, NMAX, PMAX, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_INC, PMAX, 32'hFFFF_FFFF, 1'b1, NMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_DEC, NMAX, 32'hFFFF_FFFF, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_ITF, 32'h0080_0000, 32'd0, 1'b1, PMAX, 1'b0, fpa_pkg::ST_OVF},
      '{fpa_pkg::CMD_ITF, 32'hFF80_0000, 32'd0, 1'b1, NMAX, 1'b0, fpa_pkg::ST_OK},
      '{fpa_pkg::CMD_FTI, NMAX, 32'd0, 1'b1, 32'hFF80_0000, 1'b0, fpa_pkg::ST_OK}
   };

   initial begin
      alu_out_type o;
      int wait_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         o = fixed_alu(directed[i].cmd, directed[i].a, directed[i].b);
         if (directed[i].known && (o.res !== directed[i].res || o.cmp !== directed[i].cmp
                                   || o.st !== directed[i].st))
            report("table row", o.res, directed[i].res);
         send(directed[i].cmd, directed[i].a, directed[i].b);
      end
      repeat (N_RANDOM) send(4'($urandom), rand_operand(), rand_operand());
      req_valid <= 1'b0;
      driving_done = 1'b1;
      while (pending_q.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < 2 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (errors == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule
